FILE: sv/label_run_duration_statistics_top_macros.svh
// Assertion macros for the run duration statistics checker.
`ifndef LABEL_RUN_DURATION_STATISTICS_TOP_MACROS_SVH
`define LABEL_RUN_DURATION_STATISTICS_TOP_MACROS_SVH

// A property that must hold at every sampled edge outside reset.
`define LRDS_CHECK(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// A condition that must be followed by another in the next cycle.
`define LRDS_CHECK_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`endif

FILE: sv/lrds_pkg.sv
// Types, constants and field layouts shared by the run duration statistics block.
package lrds_pkg;

    localparam int CODEBOOKS_DEF = 1024;
    localparam int MAX_RUN_DEF   = 65535;

    localparam int LABEL_W   = 10;
    localparam int LEN_W     = 16;
    localparam int CNT_W     = 32;
    localparam int SLEN_W    = 40;
    localparam int SSQ_W     = 56;
    localparam int SLOG_W    = 48;
    localparam int MEAN_W    = 32;
    localparam int VAR_W     = 48;
    localparam int CFG_CB_W  = 11;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int LIM_W     = 17;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 288;
    localparam int RLEN_LO    = LABEL_W;

    localparam int DIV_W     = SSQ_W + 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int LOG_STEPS = 30;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [CFG_CB_W-1:0] CB_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0]    VAR_RESET = 32'd65536;

    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODEBOOKS = 1'b0,
        CFG_MIN_VAR   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_JOB,
        ST_C_RD,
        ST_C_LOG,
        ST_C_MUL,
        ST_C_UPD,
        ST_Q_RD,
        ST_Q_CAP,
        ST_Q_DIV,
        ST_Q_SAVE,
        ST_Q_MUL,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SLOG_W-1:0] sum_log;
        logic [SSQ_W-1:0]  sum_sq;
        logic [SLEN_W-1:0] sum_len;
    } acc_word_t;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic load_job;
        logic job_sel;
        logic rd;
        logic log_init;
        logic log_step;
        logic log_fin;
        logic upd;
        logic last;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic div_save;
        logic mul;
        logic qout;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_query;
        logic j0_valid;
        logic j1_valid;
        logic log_last;
        logic div_last;
        logic count_zero;
        logic out_free;
    } sts_t;

endpackage

FILE: sv/lrds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lrds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lrds_ctrl.sv
// Controller state machine sequencing run closes, queries and the clearing pass.
module lrds_ctrl import lrds_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   sel_reg, sel_next;
    logic   qsel_reg, qsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            phase_reg <= 1'b0;
            sel_reg   <= 1'b0;
            qsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
            qsel_reg  <= qsel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        qsel_next  = qsel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_JOB;
                    phase_next = 1'b0;
                end
            end
            ST_JOB:
            begin
                if (sts.is_query)
                begin
                    state_next = ST_Q_RD;
                end
                else if (!phase_reg && sts.j0_valid)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_C_RD;
                end
                else if (sts.j1_valid)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_C_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_C_RD:  state_next = ST_C_LOG;
            ST_C_LOG:
            begin
                if (sts.log_last)
                begin
                    state_next = ST_C_MUL;
                end
            end
            ST_C_MUL: state_next = ST_C_UPD;
            ST_C_UPD:
            begin
                if (sts.out_free)
                begin
                    if (sel_reg || !sts.j1_valid)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        state_next = ST_JOB;
                    end
                end
            end
            ST_Q_RD:  state_next = ST_Q_CAP;
            ST_Q_CAP:
            begin
                if (sts.count_zero)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    qsel_next  = 1'b0;
                    state_next = ST_Q_DIV;
                end
            end
            ST_Q_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_Q_SAVE;
                end
            end
            ST_Q_SAVE:
            begin
                if (!qsel_reg)
                begin
                    qsel_next  = 1'b1;
                    state_next = ST_Q_DIV;
                end
                else
                begin
                    state_next = ST_Q_MUL;
                end
            end
            ST_Q_MUL: state_next = ST_Q_OUT;
            ST_Q_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_wr = 1'b1;
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_JOB:
            begin
                cmd.load_job = !sts.is_query &&
                               ((!phase_reg && sts.j0_valid) || sts.j1_valid);
                cmd.job_sel  = !(!phase_reg && sts.j0_valid);
            end
            ST_C_RD:
            begin
                cmd.rd       = 1'b1;
                cmd.log_init = 1'b1;
            end
            ST_C_LOG: cmd.log_step = 1'b1;
            ST_C_MUL: cmd.log_fin  = 1'b1;
            ST_C_UPD:
            begin
                cmd.upd  = sts.out_free;
                cmd.last = sel_reg || !sts.j1_valid;
            end
            ST_Q_RD:  cmd.rd = 1'b1;
            ST_Q_CAP:
            begin
                cmd.div_init = !sts.count_zero;
                cmd.div_sel  = 1'b0;
            end
            ST_Q_DIV: cmd.div_step = 1'b1;
            ST_Q_SAVE:
            begin
                cmd.div_save = 1'b1;
                cmd.div_init = !qsel_reg;
                cmd.div_sel  = 1'b1;
            end
            ST_Q_MUL: cmd.mul  = 1'b1;
            ST_Q_OUT: cmd.qout = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

FILE: sv/lrds_dp.sv
// Datapath: run tracking, accumulator memory, log, divider and output register.
module lrds_dp import lrds_pkg::*; #(
    parameter int CODEBOOKS = CODEBOOKS_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int ADDR_W = $clog2(CODEBOOKS);

    logic [CFG_CB_W-1:0] cfg_cb_reg;
    logic [CFG_W-1:0]    cfg_var_reg;

    logic [LABEL_W-1:0] open_label_reg;
    logic [LEN_W-1:0]   open_len_reg;
    logic               run_active_reg;
    logic               is_query_reg;
    logic               j0_valid_reg, j1_valid_reg;
    logic [LABEL_W-1:0] j0_lab_reg, j1_lab_reg, cur_lab_reg;
    logic [LEN_W-1:0]   j0_len_reg, j1_len_reg, cur_len_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [31:0]          y_reg;
    logic [3:0]           e_reg;
    logic [LOG_STEPS-1:0] frac_reg;
    logic [4:0]           log_cnt_reg;
    logic [63:0]          lnp_reg;

    logic [DIV_W-1:0]     dvd_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 div_sel_reg;
    logic [VAR_W-1:0]     ms_reg;
    logic [MEAN_W-1:0]    m_reg;
    logic [VAR_W-1:0]     msq_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    acc_word_t ram_rdata, ram_wdata, upd_word;
    logic      ram_we;
    logic [ADDR_W-1:0] ram_waddr;

    // Label clamping against the codebooks in use.
    logic [LABEL_W-1:0] lab_in, lab;
    logic [LIM_W-1:0]   n_raw, n_eff, n_less;

    assign lab_in = s_tdata[LABEL_W-1:0];
    assign n_raw  = LIM_W'(cfg_cb_reg);
    assign n_less = n_eff - LIM_W'(1);

    always_comb
    begin
        if (n_raw == '0)
        begin
            n_eff = LIM_W'(1);
        end
        else if (n_raw > LIM_W'(CODEBOOKS))
        begin
            n_eff = LIM_W'(CODEBOOKS);
        end
        else
        begin
            n_eff = n_raw;
        end
        lab = (LIM_W'(lab_in) >= n_eff) ? n_less[LABEL_W-1:0] : lab_in;
    end

    // Run tracking for a frame word.
    logic             extend;
    logic [LEN_W-1:0] new_len;

    assign extend = run_active_reg && (lab == open_label_reg);

    always_comb
    begin
        if (!extend)
        begin
            new_len = LEN_W'(1);
        end
        else if (open_len_reg < LEN_W'(MAX_RUN))
        begin
            new_len = open_len_reg + LEN_W'(1);
        end
        else
        begin
            new_len = open_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cb_reg     <= CB_RESET;
            cfg_var_reg    <= VAR_RESET;
            open_label_reg <= '0;
            open_len_reg   <= '0;
            run_active_reg <= 1'b0;
            is_query_reg   <= 1'b0;
            j0_valid_reg   <= 1'b0;
            j1_valid_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CODEBOOKS: cfg_cb_reg  <= cfg_data[CFG_CB_W-1:0];
                    CFG_MIN_VAR:   cfg_var_reg <= cfg_data;
                    default:       cfg_cb_reg  <= cfg_cb_reg;
                endcase
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.accept)
            begin
                is_query_reg <= s_tuser;
                if (s_tuser)
                begin
                    j0_valid_reg <= 1'b0;
                    j1_valid_reg <= 1'b0;
                end
                else
                begin
                    j0_valid_reg   <= run_active_reg && !extend;
                    j1_valid_reg   <= s_tlast;
                    open_label_reg <= lab;
                    open_len_reg   <= s_tlast ? '0 : new_len;
                    run_active_reg <= !s_tlast;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_lab_reg <= lab;
            j0_lab_reg  <= open_label_reg;
            j0_len_reg  <= open_len_reg;
            j1_lab_reg  <= lab;
            j1_len_reg  <= new_len;
        end
        else if (cmd.load_job)
        begin
            cur_lab_reg <= cmd.job_sel ? j1_lab_reg : j0_lab_reg;
            cur_len_reg <= cmd.job_sel ? j1_len_reg : j0_len_reg;
        end
    end

    // Natural log: log2 by repeated squaring, one fraction bit per cycle.
    logic [3:0]  e_enc;
    logic [63:0] y_sq;
    logic [32:0] y_next;

    always_comb
    begin
        e_enc = '0;
        for (int i = 0; i < LEN_W; i++)
        begin
            if (cur_len_reg[i])
            begin
                e_enc = 4'(i);
            end
        end
    end

    assign y_sq   = 64'(y_reg) * 64'(y_reg);
    assign y_next = y_sq[63:31];

    always_ff @(posedge clk)
    begin
        if (cmd.log_init)
        begin
            y_reg       <= 32'(cur_len_reg) << (5'd31 - {1'b0, e_enc});
            e_reg       <= e_enc;
            frac_reg    <= '0;
            log_cnt_reg <= 5'(LOG_STEPS - 1);
        end
        else if (cmd.log_step)
        begin
            if (y_next[32])
            begin
                y_reg <= y_next[32:1];
                frac_reg[log_cnt_reg] <= 1'b1;
            end
            else
            begin
                y_reg <= y_next[31:0];
            end
            log_cnt_reg <= log_cnt_reg - 5'd1;
        end
        if (cmd.log_fin)
        begin
            lnp_reg <= 64'({e_reg, frac_reg}) * 64'(LN2_Q30);
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [CNT_W:0] rem_s, rem_d;
    logic           ge;
    logic [63:0]    y_sq_m;

    assign rem_s  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_d  = rem_s - {1'b0, ram_rdata.count};
    assign ge     = rem_s >= {1'b0, ram_rdata.count};
    assign y_sq_m = 64'(m_reg) * 64'(m_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_save)
        begin
            if (!div_sel_reg)
            begin
                ms_reg <= (|dvd_reg[DIV_W-1:VAR_W]) ? '1 : dvd_reg[VAR_W-1:0];
            end
            else
            begin
                m_reg <= (|dvd_reg[DIV_W-1:MEAN_W]) ? '1 : dvd_reg[MEAN_W-1:0];
            end
        end
        if (cmd.div_init)
        begin
            div_sel_reg <= cmd.div_sel;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            if (cmd.div_sel)
            begin
                dvd_reg <= {16'd0, ram_rdata.sum_len, 16'd0};
            end
            else
            begin
                dvd_reg <= {ram_rdata.sum_sq, 16'd0};
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= ge ? rem_d[CNT_W-1:0] : rem_s[CNT_W-1:0];
            dvd_reg     <= {dvd_reg[DIV_W-2:0], ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.mul)
        begin
            msq_reg <= y_sq_m[63:16];
        end
    end

    // Saturating accumulator update for a closed run.
    logic [CNT_W:0]  cnt_sum;
    logic [SLEN_W:0] len_sum;
    logic [31:0]     len_sq;
    logic [SSQ_W:0]  sq_sum;
    logic [64:0]     ln_round;
    logic [SLOG_W:0] log_sum;

    assign cnt_sum  = {1'b0, ram_rdata.count} + (CNT_W+1)'(1);
    assign len_sum  = {1'b0, ram_rdata.sum_len} + (SLEN_W+1)'(cur_len_reg);
    assign len_sq   = 32'(cur_len_reg) * 32'(cur_len_reg);
    assign sq_sum   = {1'b0, ram_rdata.sum_sq} + (SSQ_W+1)'(len_sq);
    assign ln_round = {1'b0, lnp_reg} + (65'd1 << 43);
    assign log_sum  = {1'b0, ram_rdata.sum_log} + (SLOG_W+1)'(ln_round[63:44]);

    always_comb
    begin
        upd_word.count   = cnt_sum[CNT_W]   ? '1 : cnt_sum[CNT_W-1:0];
        upd_word.sum_len = len_sum[SLEN_W]  ? '1 : len_sum[SLEN_W-1:0];
        upd_word.sum_sq  = sq_sum[SSQ_W]    ? '1 : sq_sum[SSQ_W-1:0];
        upd_word.sum_log = log_sum[SLOG_W]  ? '1 : log_sum[SLOG_W-1:0];
    end

    assign ram_we    = cmd.clr_wr || cmd.upd;
    assign ram_waddr = cmd.clr_wr ? clr_cnt_reg : ADDR_W'(cur_lab_reg);
    assign ram_wdata = cmd.clr_wr ? acc_word_t'('0) : upd_word;

    lrds_ram #(
        .WIDTH ($bits(acc_word_t)),
        .DEPTH (CODEBOOKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (ADDR_W'(cur_lab_reg)),
        .rdata (ram_rdata)
    );

    // Query variance with floor.
    logic [VAR_W-1:0] var_diff, var_floor;
    logic             count_zero;

    assign count_zero = (ram_rdata.count == '0);
    assign var_diff   = (ms_reg > msq_reg) ? (ms_reg - msq_reg) : '0;
    assign var_floor  = (var_diff < VAR_W'(cfg_var_reg)) ? VAR_W'(cfg_var_reg) : var_diff;

    always_comb
    begin
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_last_next = out_last_reg;
        if (cmd.upd)
        begin
            out_data_next = {5'd0, 1'b0, {VAR_W{1'b0}}, {MEAN_W{1'b0}},
                             upd_word.sum_log, upd_word.sum_sq, upd_word.sum_len,
                             upd_word.count, cur_len_reg, cur_lab_reg};
            out_user_next = KIND_RUN;
            out_last_next = cmd.last;
        end
        else if (cmd.qout)
        begin
            out_data_next = {5'd0, count_zero,
                             count_zero ? {VAR_W{1'b0}} : var_floor,
                             count_zero ? {MEAN_W{1'b0}} : m_reg,
                             ram_rdata.sum_log, ram_rdata.sum_sq, ram_rdata.sum_len,
                             ram_rdata.count, {LEN_W{1'b0}}, cur_lab_reg};
            out_user_next = KIND_QUERY;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.upd || cmd.qout)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        sts.clr_done   = cmd.clr_wr && (clr_cnt_reg == ADDR_W'(CODEBOOKS - 1));
        sts.is_query   = is_query_reg;
        sts.j0_valid   = j0_valid_reg;
        sts.j1_valid   = j1_valid_reg;
        sts.log_last   = (log_cnt_reg == 5'd0);
        sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_W - 1));
        sts.count_zero = count_zero;
        sts.out_free   = !out_valid_reg || m_tready;
    end

endmodule

FILE: sv/label_run_duration_statistics_top.sv
// Run duration statistics: a frame word that closes no run produces no record.
// Each closed run goes through read, 30-step log, multiply and update;
// its record is then registered for output and held while the output stalls.
// A query runs the one-bit-per-cycle divider twice (72 steps each),
// or skips it for a codebook with no runs; output stalls can delay both.
// After reset a clearing pass zeroes all CODEBOOKS memory words; no word is accepted meanwhile.
module label_run_duration_statistics_top import lrds_pkg::*; #(
    parameter int CODEBOOKS = CODEBOOKS_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // codebook
    input  logic                  s_tuser,   // action
    input  logic                  s_tlast,   // utterance_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // class_index, run_length, run_count, sum_length, sum_square, sum_log,
    // mean_length, variance, no_runs
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // kind
    output logic                  m_tlast    // last
);

    cmd_t cmd;
    sts_t sts;

    lrds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrds_dp #(
        .CODEBOOKS (CODEBOOKS),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/lrds_checker.sv
// Port-level checks for the run duration statistics block, bound to its top level.
`include "label_run_duration_statistics_top_macros.svh"

module lrds_checker import lrds_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // A stalled result word holds.
    `LRDS_CHECK_NEXT(stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // One word is worked on at a time: the cycle after acceptance the input is closed.
    `LRDS_CHECK_NEXT(one_at_a_time, s_tvalid && s_tready, !s_tready)

    // A query answer is always the only and final result of its word.
    `LRDS_CHECK(query_is_last, !(m_tvalid && m_tuser == KIND_QUERY) || m_tlast)

    // A closed run is never empty, and a query never carries a run length.
    `LRDS_CHECK(run_len_kind, !m_tvalid ||
        ((m_tuser == KIND_QUERY) == (m_tdata[RLEN_LO +: LEN_W] == '0)))

endmodule

bind label_run_duration_statistics_top lrds_checker u_checker (.*);
